/* rtl/core/dop_pkg.sv */
// Shared types and constants for the DHCP options parser.
`timescale 1ns / 1ps
`default_nettype none

package dop_pkg;

   // Walk position within one code-length-value entry.
   typedef enum logic [1:0] {
      PH_CODE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   localparam logic [7:0] CODE_PAD    = 8'd0;
   localparam logic [7:0] CODE_MASK   = 8'd1;
   localparam logic [7:0] CODE_ROUTER = 8'd3;
   localparam logic [7:0] CODE_TYPE   = 8'd53;
   localparam logic [7:0] CODE_SERVER = 8'd54;
   localparam logic [7:0] CODE_END    = 8'd255;

   // Bit positions in the found-flag vector.
   localparam int FLAG_TYPE   = 0;
   localparam int FLAG_MASK   = 1;
   localparam int FLAG_ROUTER = 2;
   localparam int FLAG_SERVER = 3;

   // Number of value bytes that make up a four-byte option value.
   localparam logic [2:0] VALUE_BYTES = 3'd4;

   localparam int RSP_DATA_W = 112;

   // One parse result, handed from the walker to the output register.
   typedef struct packed {
      logic        emit;
      logic [7:0]  message_type;
      logic [31:0] subnet_mask;
      logic [31:0] router_addr;
      logic [31:0] server_ident;
      logic [3:0]  found;
      logic        truncated;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/dop_walker.sv */
// Code-length-value walker holding the parse state and the captured option values.
`timescale 1ns / 1ps
`default_nettype none

module dop_walker
   import dop_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] opt_byte,
   input  wire logic       first_byte,
   input  wire logic       last_byte,
   output result_type      result
);

   phase_type   phase_ff,  phase_in;
   logic [7:0]  code_ff,   code_in;
   logic [7:0]  left_ff,   left_in;
   logic [2:0]  index_ff,  index_in;
   logic [31:0] acc_ff,    acc_in;
   logic [7:0]  type_ff,   type_in;
   logic [31:0] mask_ff,   mask_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] server_ff, server_in;
   logic [3:0]  found_ff,  found_in;
   logic        emit;
   logic        trunc;
   logic        walked;

   always_comb begin
      phase_in  = phase_ff;
      code_in   = code_ff;
      left_in   = left_ff;
      index_in  = index_ff;
      acc_in    = acc_ff;
      type_in   = type_ff;
      mask_in   = mask_ff;
      router_in = router_ff;
      server_in = server_ff;
      found_in  = found_ff;
      emit      = 1'b0;
      trunc     = 1'b0;
      walked    = 1'b0;

      // The first byte of a buffer restarts the walk from a clean slate.
      if (first_byte) begin
         phase_in  = PH_CODE;
         code_in   = '0;
         left_in   = '0;
         index_in  = '0;
         acc_in    = '0;
         type_in   = '0;
         mask_in   = '0;
         router_in = '0;
         server_in = '0;
         found_in  = '0;
      end

      case (phase_in)
         PH_CODE: begin
            if (opt_byte == CODE_END) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
            end else begin
               walked = 1'b1;
               if (opt_byte != CODE_PAD) begin
                  code_in  = opt_byte;
                  phase_in = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            walked   = 1'b1;
            left_in  = opt_byte;
            index_in = '0;
            acc_in   = '0;
            phase_in = (opt_byte == 8'd0) ? PH_CODE : PH_VALUE;
         end
         PH_VALUE: begin
            walked = 1'b1;
            if (index_in == 3'd0 && code_in == CODE_TYPE) begin
               type_in             = opt_byte;
               found_in[FLAG_TYPE] = 1'b1;
            end
            // Only the first four value bytes form the value; the rest are skipped.
            if (index_in < VALUE_BYTES) begin
               acc_in   = {acc_in[23:0], opt_byte};
               index_in = index_in + 3'd1;
               if (index_in == VALUE_BYTES) begin
                  if (code_in == CODE_MASK) begin
                     mask_in             = acc_in;
                     found_in[FLAG_MASK] = 1'b1;
                  end else if (code_in == CODE_ROUTER) begin
                     router_in             = acc_in;
                     found_in[FLAG_ROUTER] = 1'b1;
                  end else if (code_in == CODE_SERVER) begin
                     server_in             = acc_in;
                     found_in[FLAG_SERVER] = 1'b1;
                  end
               end
            end
            left_in = left_in - 8'd1;
            if (left_in == 8'd0) begin
               phase_in = PH_CODE;
            end
         end
         default: begin
            // Parse finished: bytes are ignored until the next first byte.
         end
      endcase

      if (walked && last_byte) begin
         phase_in = PH_DONE;
         emit     = 1'b1;
         trunc    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CODE;
         code_ff   <= '0;
         left_ff   <= '0;
         index_ff  <= '0;
         acc_ff    <= '0;
         type_ff   <= '0;
         mask_ff   <= '0;
         router_ff <= '0;
         server_ff <= '0;
         found_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         left_ff   <= left_in;
         index_ff  <= index_in;
         acc_ff    <= acc_in;
         type_ff   <= type_in;
         mask_ff   <= mask_in;
         router_ff <= router_in;
         server_ff <= server_in;
         found_ff  <= found_in;
      end
   end

   always_comb begin
      result.emit         = emit;
      result.message_type = type_in;
      result.subnet_mask  = mask_in;
      result.router_addr  = router_in;
      result.server_ident = server_in;
      result.found        = found_in;
      result.truncated    = trunc;
   end

endmodule

`default_nettype wire

/* rtl/core/dhcp_option_parser_top.sv */
// Top level of the DHCP options parser: input channel, walker and result register.
`timescale 1ns / 1ps
`default_nettype none

// DHCP options parser.
// The req channel carries the options area of a DHCP message, one byte per item:
// req_tdata holds the byte, req_tuser marks the first byte of a buffer (it clears
// every captured value and restarts the walk) and req_tlast marks the last byte.
// The walker follows code-length-value entries, skipping pad bytes and unknown
// codes, and captures message type, subnet mask, router and server identifier.
// One item leaves on the rsp channel when the end code arrives, or at the last
// byte of the buffer when no end code came first; then the truncated bit is set.
// Bytes after the end code are ignored until a new first byte arrives.
// Throughput is one byte per cycle while no stalled result holds up the input: the
// state update for a byte is a single pass through the walker logic, done in the
// cycle the byte is accepted. The result appears on rsp in the cycle after the
// byte that produced it was accepted, from the result register.
// A stalled receiver only holds up the input while a result waits in that
// register; bytes that produce no result still need that register to be free.
// Reset is synchronous and active high; it returns the walker to expect a code
// with every captured value and found flag cleared, and empties the result register.

module dhcp_option_parser_top
   import dop_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] opt_byte
   input  wire logic                  req_tuser,  // [0] first_byte
   input  wire logic                  req_tlast,  // last_byte
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] message_type, [39:8] subnet_mask, [71:40] router_addr,
   // [103:72] server_ident, [104] type_found, [105] mask_found,
   // [106] router_found, [107] server_found, [108] truncated, [111:109] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   result_type            result;
   logic                  req_accept;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // The result register is the only thing that can hold up the input.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   dop_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .opt_byte   (req_tdata),
      .first_byte (req_tuser),
      .last_byte  (req_tlast),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && result.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000,
                         result.truncated,
                         result.found[FLAG_SERVER],
                         result.found[FLAG_ROUTER],
                         result.found[FLAG_MASK],
                         result.found[FLAG_TYPE],
                         result.server_ident,
                         result.router_addr,
                         result.subnet_mask,
                         result.message_type};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A waiting result that is not taken must block the input.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while a result was stalled");

   // A byte that finishes a parse shows its result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && result.emit) |=> rsp_valid_ff)
      else $error("finished parse gave no result");

   // A byte that finishes nothing leaves the result register empty.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !result.emit) |=> !rsp_valid_ff)
      else $error("result appeared without a finishing byte");

endmodule

`default_nettype wire
